### design/aarm_pkg.sv
// Shared constants, types and tables for the axis-angle rotation matrix pipeline.
package aarm_pkg;

    // Field widths and step counts
    localparam int IN_W          = 32;
    localparam int CORDIC_STEPS  = 18;
    localparam int OUT_FRAC_BITS = 16;
    localparam int OUT_W         = OUT_FRAC_BITS + 2;
    localparam int MOD_STEPS     = 7;
    localparam int LZ_STEPS      = 5;

    // Angle reduction, Q16.16 degrees
    localparam int R_W = 26;
    localparam logic [IN_W-1:0]        FULL_TURN     = 32'd23592960;
    localparam logic signed [R_W-1:0]  FULL_TURN_R   = 26'sd23592960;
    localparam logic signed [R_W-1:0]  HALF_TURN     = 26'sd11796480;
    localparam logic signed [R_W-1:0]  QUARTER_TURN  = 26'sd5898240;
    localparam logic signed [R_W-1:0]  THREE_QUARTER = 26'sd17694720;
    localparam int D2R_W  = 28;
    localparam logic signed [D2R_W-1:0] DEG2RAD_Q32 = 28'sd74961320;
    localparam int PROD_W = R_W + D2R_W;

    // Trig, axis and accumulator widths
    localparam int CS_W   = 34;
    localparam int T_W    = 35;
    localparam int U_W    = 32;
    localparam int TU_W   = 36;
    localparam int TP_W   = T_W + U_W;
    localparam int ACC_W  = 72;
    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [T_W-1:0]  ONE_Q30     = 35'sd1073741824;

    // Length and divide widths
    localparam int SQ_W   = 64;
    localparam int ROOT_W = 32;
    localparam int SREM_W = 36;
    localparam int Q_W    = 31;
    localparam int DREM_W = 34;

    // Latency of each unit
    localparam int ANG_LAT  = MOD_STEPS + CORDIC_STEPS + 6;
    localparam int NORM_LAT = 2 + LZ_STEPS + 2 + ROOT_W + Q_W + 1;
    localparam int MAT_LAT  = 5;

    typedef struct packed {
        logic signed [IN_W-1:0] x;
        logic signed [IN_W-1:0] y;
        logic signed [IN_W-1:0] z;
    } t_axis;

    typedef struct packed {
        logic signed [CS_W-1:0] c;
        logic signed [CS_W-1:0] s;
        logic signed [T_W-1:0]  t;
    } t_trig;

    typedef struct packed {
        t_trig trig;
        t_axis axis;
    } t_ang_res;

    typedef struct packed {
        t_trig trig;
        logic signed [U_W-1:0] ux;
        logic signed [U_W-1:0] uy;
        logic signed [U_W-1:0] uz;
    } t_norm_res;

    typedef logic signed [OUT_W-1:0] t_entry;

    typedef struct packed {
        t_entry m00; t_entry m01; t_entry m02;
        t_entry m10; t_entry m11; t_entry m12;
        t_entry m20; t_entry m21; t_entry m22;
    } t_mat;

    // Arctangent of 2^-i in Q2.30
    function automatic logic signed [CS_W-1:0] atan_q30(input int unsigned i);
        logic signed [CS_W-1:0] v;
        case (i)
            0:  v = 34'sd843314856;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043836;
            3:  v = 34'sd133525158;
            4:  v = 34'sd67021686;
            5:  v = 34'sd33543515;
            6:  v = 34'sd16775850;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194282;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048575;
            11: v = 34'sd524287;
            12: v = 34'sd262143;
            13: v = 34'sd131071;
            14: v = 34'sd65535;
            15: v = 34'sd32767;
            16: v = 34'sd16383;
            17: v = 34'sd8191;
            18: v = 34'sd4095;
            19: v = 34'sd2047;
            20: v = 34'sd1023;
            21: v = 34'sd511;
            22: v = 34'sd255;
            23: v = 34'sd127;
            24: v = 34'sd63;
            25: v = 34'sd31;
            26: v = 34'sd15;
            27: v = 34'sd8;
            28: v = 34'sd4;
            29: v = 34'sd2;
            30: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### design/aarm_if.sv
// Valid/ready channel interfaces for the input axis-angle word and the output matrix word.
interface aarm_in_if;
    logic                 valid;
    logic                 ready;
    logic signed [31:0]   angle_deg;
    logic signed [31:0]   axis_x;
    logic signed [31:0]   axis_y;
    logic signed [31:0]   axis_z;
    modport source (output valid, angle_deg, axis_x, axis_y, axis_z, input ready);
    modport sink   (input valid, angle_deg, axis_x, axis_y, axis_z, output ready);
endinterface

interface aarm_out_if;
    logic                 valid;
    logic                 ready;
    logic signed [17:0]   m00;
    logic signed [17:0]   m01;
    logic signed [17:0]   m02;
    logic signed [17:0]   m10;
    logic signed [17:0]   m11;
    logic signed [17:0]   m12;
    logic signed [17:0]   m20;
    logic signed [17:0]   m21;
    logic signed [17:0]   m22;
    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

### design/aarm_angle.sv
// Angle unit: modulo-360 reduction, quadrant fold, degree-to-radian scaling and CORDIC.
module aarm_angle (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [31:0]  i_angle,
    input  aarm_pkg::t_axis     i_axis,
    output logic                o_valid,
    output aarm_pkg::t_ang_res  o_res
);
    localparam int LAT    = aarm_pkg::ANG_LAT;
    localparam int MS     = aarm_pkg::MOD_STEPS;
    localparam int CS     = aarm_pkg::CORDIC_STEPS;
    localparam int IN_W   = aarm_pkg::IN_W;
    localparam int R_W    = aarm_pkg::R_W;
    localparam int CS_W   = aarm_pkg::CS_W;
    localparam int T_W    = aarm_pkg::T_W;
    localparam int PROD_W = aarm_pkg::PROD_W;
    localparam int S_FOLD = MS + 2;
    localparam logic signed [PROD_W-1:0] RND18 = PROD_W'(1) << 17;

    logic [LAT-1:0]              r_vld;
    aarm_pkg::t_axis             r_axd  [0:LAT-1];
    logic [IN_W-1:0]             r_mag  [0:MS];
    logic [IN_W-1:0]             n_mag  [0:MS];
    logic                        r_neg  [0:MS];
    logic signed [R_W-1:0]       r_wrap, n_wrap, r_fold, n_fold;
    logic signed [R_W-1:0]       w_mod;
    logic                        n_flip;
    logic                        r_flip [S_FOLD:LAT-2];
    logic signed [PROD_W-1:0]    r_prod, n_prod, w_rsum;
    logic signed [CS_W-1:0]      r_x [0:CS];
    logic signed [CS_W-1:0]      r_y [0:CS];
    logic signed [CS_W-1:0]      r_z [0:CS];
    logic signed [CS_W-1:0]      n_x [0:CS];
    logic signed [CS_W-1:0]      n_y [0:CS];
    logic signed [CS_W-1:0]      n_z [0:CS];
    logic signed [CS_W-1:0]      w_c, w_s;
    aarm_pkg::t_trig             r_trig;

    // Stage logic
    always_comb begin
        // magnitude, then restoring subtraction of shifted full turns
        n_mag[0] = i_angle[IN_W-1] ? IN_W'(-i_angle) : IN_W'(i_angle);
        for (int k = 1; k <= MS; k++) begin
            n_mag[k] = (r_mag[k-1] >= (FULL_TURN_SH(MS - k)))
                     ? r_mag[k-1] - FULL_TURN_SH(MS - k) : r_mag[k-1];
        end
        // negative angles wrap back into [0, 360)
        w_mod  = $signed(r_mag[MS][R_W-1:0]);
        n_wrap = (r_neg[MS] && (w_mod != '0)) ? aarm_pkg::FULL_TURN_R - w_mod : w_mod;
        // fold into [-90, 90]; a half-turn fold negates cosine and sine
        if (r_wrap <= aarm_pkg::QUARTER_TURN) begin
            n_fold = r_wrap;
            n_flip = 1'b0;
        end else if (r_wrap < aarm_pkg::THREE_QUARTER) begin
            n_fold = r_wrap - aarm_pkg::HALF_TURN;
            n_flip = 1'b1;
        end else begin
            n_fold = r_wrap - aarm_pkg::FULL_TURN_R;
            n_flip = 1'b0;
        end
        n_prod = r_fold * aarm_pkg::DEG2RAD_Q32;
        w_rsum = r_prod + RND18;
        // CORDIC seed, then one rotation per stage
        n_x[0] = aarm_pkg::CORDIC_GAIN;
        n_y[0] = '0;
        n_z[0] = CS_W'(w_rsum >>> 18);
        for (int i = 0; i < CS; i++) begin
            if (!r_z[i][CS_W-1]) begin
                n_x[i+1] = r_x[i] - (r_y[i] >>> i);
                n_y[i+1] = r_y[i] + (r_x[i] >>> i);
                n_z[i+1] = r_z[i] - aarm_pkg::atan_q30(i);
            end else begin
                n_x[i+1] = r_x[i] + (r_y[i] >>> i);
                n_y[i+1] = r_y[i] - (r_x[i] >>> i);
                n_z[i+1] = r_z[i] + aarm_pkg::atan_q30(i);
            end
        end
        w_c = r_flip[LAT-2] ? -r_x[CS] : r_x[CS];
        w_s = r_flip[LAT-2] ? -r_y[CS] : r_y[CS];
    end

    function automatic logic [IN_W-1:0] FULL_TURN_SH(input int sh);
        return aarm_pkg::FULL_TURN << sh;
    endfunction

    // Valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_axd[0] <= i_axis;
            for (int k = 1; k < LAT; k++) r_axd[k] <= r_axd[k-1];
            r_neg[0] <= i_angle[IN_W-1];
            for (int k = 0; k <= MS; k++) r_mag[k] <= n_mag[k];
            for (int k = 1; k <= MS; k++) r_neg[k] <= r_neg[k-1];
            r_wrap <= n_wrap;
            r_fold <= n_fold;
            r_flip[S_FOLD] <= n_flip;
            for (int k = S_FOLD + 1; k <= LAT - 2; k++) r_flip[k] <= r_flip[k-1];
            r_prod <= n_prod;
            for (int i = 0; i <= CS; i++) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
                r_z[i] <= n_z[i];
            end
            r_trig.c <= w_c;
            r_trig.s <= w_s;
            r_trig.t <= aarm_pkg::ONE_Q30 - T_W'(w_c);
        end
    end

    assign o_valid     = r_vld[LAT-1];
    assign o_res.trig  = r_trig;
    assign o_res.axis  = r_axd[LAT-1];

endmodule

### design/aarm_norm.sv
// Axis normaliser: leading-zero scaling, sum of squares, bit-serial square root and divide.
module aarm_norm (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  aarm_pkg::t_ang_res   i_res,
    output logic                 o_valid,
    output aarm_pkg::t_norm_res  o_res
);
    localparam int LAT    = aarm_pkg::NORM_LAT;
    localparam int IN_W   = aarm_pkg::IN_W;
    localparam int LZ     = aarm_pkg::LZ_STEPS;
    localparam int SQ_W   = aarm_pkg::SQ_W;
    localparam int ROOT_W = aarm_pkg::ROOT_W;
    localparam int SREM_W = aarm_pkg::SREM_W;
    localparam int Q_W    = aarm_pkg::Q_W;
    localparam int DREM_W = aarm_pkg::DREM_W;
    localparam int U_W    = aarm_pkg::U_W;
    localparam int S_LZE  = 1 + LZ;
    localparam int S_DIV  = S_LZE + 3 + ROOT_W;

    typedef struct packed {
        logic sx;
        logic sy;
        logic sz;
        logic zero;
    } t_flags;

    logic [LAT-1:0]          r_vld;
    aarm_pkg::t_trig         r_trg [0:LAT-1];
    t_flags                  r_flg [0:LAT-2];
    logic [IN_W-1:0]         r_mag [0:S_DIV-1][0:2];
    logic [IN_W-1:0]         n_mag [0:S_DIV-1][0:2];
    logic [IN_W-1:0]         r_mx  [1:S_LZE];
    logic [IN_W-1:0]         n_mx  [1:S_LZE];
    logic [SQ_W-1:0]         r_sq  [0:2];
    logic [SQ_W-1:0]         r_sum;
    logic [SREM_W-1:0]       r_srem [0:ROOT_W-1];
    logic [ROOT_W-1:0]       r_root [0:ROOT_W-1];
    logic [SQ_W-1:0]         r_sval [0:ROOT_W-1];
    logic [SREM_W-1:0]       n_srem [0:ROOT_W-1];
    logic [ROOT_W-1:0]       n_root [0:ROOT_W-1];
    logic [SQ_W-1:0]         n_sval [0:ROOT_W-1];
    logic [SREM_W-1:0]       w_cur  [0:ROOT_W-1];
    logic [SREM_W-1:0]       w_try  [0:ROOT_W-1];
    logic [ROOT_W-1:0]       r_len  [0:Q_W-1];
    logic [DREM_W-1:0]       r_drem [0:Q_W-1][0:2];
    logic [Q_W-1:0]          r_q    [0:Q_W-1][0:2];
    logic [DREM_W-1:0]       n_drem [0:Q_W-1][0:2];
    logic [Q_W-1:0]          n_q    [0:Q_W-1][0:2];
    logic [DREM_W-1:0]       w_d2   [1:Q_W-1][0:2];
    logic                    w_b0   [0:2];
    logic signed [U_W-1:0]   r_u    [0:2];
    logic signed [U_W-1:0]   n_u    [0:2];
    logic                    w_neg  [0:2];
    logic signed [IN_W-1:0]  w_a    [0:2];

    // Stage logic
    always_comb begin
        w_a[0] = i_res.axis.x;
        w_a[1] = i_res.axis.y;
        w_a[2] = i_res.axis.z;
        for (int j = 0; j < 3; j++) begin
            n_mag[0][j] = w_a[j][IN_W-1] ? IN_W'(-w_a[j]) : IN_W'(w_a[j]);
            n_mag[1][j] = r_mag[0][j];
        end
        // largest magnitude
        n_mx[1] = r_mag[0][0];
        if (r_mag[0][1] > n_mx[1]) n_mx[1] = r_mag[0][1];
        if (r_mag[0][2] > n_mx[1]) n_mx[1] = r_mag[0][2];
        // binary search for the left shift that lifts the largest to at least 2^30
        for (int k = 0; k < LZ; k++) begin
            if (r_mx[k+1] < (IN_W'(1) << (IN_W - 1 - (16 >> k)))) begin
                n_mx[k+2] = r_mx[k+1] << (16 >> k);
                for (int j = 0; j < 3; j++) n_mag[k+2][j] = r_mag[k+1][j] << (16 >> k);
            end else begin
                n_mx[k+2] = r_mx[k+1];
                for (int j = 0; j < 3; j++) n_mag[k+2][j] = r_mag[k+1][j];
            end
        end
        for (int s = S_LZE + 1; s < S_DIV; s++) begin
            for (int j = 0; j < 3; j++) n_mag[s][j] = r_mag[s-1][j];
        end
        // square root, two radicand bits per stage
        for (int k = 0; k < ROOT_W; k++) begin
            if (k == 0) begin
                w_cur[k] = SREM_W'(r_sum[SQ_W-1 -: 2]);
                w_try[k] = SREM_W'(2'b01);
            end else begin
                w_cur[k] = {r_srem[k-1][SREM_W-3:0], r_sval[k-1][SQ_W-1 -: 2]};
                w_try[k] = SREM_W'({r_root[k-1], 2'b01});
            end
            if (w_cur[k] >= w_try[k]) begin
                n_srem[k] = w_cur[k] - w_try[k];
                n_root[k] = (k == 0) ? ROOT_W'(1) : {r_root[k-1][ROOT_W-2:0], 1'b1};
            end else begin
                n_srem[k] = w_cur[k];
                n_root[k] = (k == 0) ? '0 : {r_root[k-1][ROOT_W-2:0], 1'b0};
            end
            n_sval[k] = (k == 0) ? (r_sum << 2) : (r_sval[k-1] << 2);
        end
        // divide: top quotient bit first, then one bit per stage
        for (int j = 0; j < 3; j++) begin
            w_b0[j]      = r_mag[S_DIV-1][j] >= r_root[ROOT_W-1];
            n_drem[0][j] = DREM_W'(r_mag[S_DIV-1][j] - (w_b0[j] ? r_root[ROOT_W-1] : '0));
            n_q[0][j]    = Q_W'(w_b0[j]);
        end
        for (int k = 1; k < Q_W; k++) begin
            for (int j = 0; j < 3; j++) begin
                w_d2[k][j] = {r_drem[k-1][j][DREM_W-2:0], 1'b0};
                if (w_d2[k][j] >= DREM_W'(r_len[k-1])) begin
                    n_drem[k][j] = w_d2[k][j] - DREM_W'(r_len[k-1]);
                    n_q[k][j]    = {r_q[k-1][j][Q_W-2:0], 1'b1};
                end else begin
                    n_drem[k][j] = w_d2[k][j];
                    n_q[k][j]    = {r_q[k-1][j][Q_W-2:0], 1'b0};
                end
            end
        end
        // restore sign; a zero axis stays zero
        w_neg[0] = r_flg[LAT-2].sx;
        w_neg[1] = r_flg[LAT-2].sy;
        w_neg[2] = r_flg[LAT-2].sz;
        for (int j = 0; j < 3; j++) begin
            if (r_flg[LAT-2].zero) begin
                n_u[j] = '0;
            end else if (w_neg[j]) begin
                n_u[j] = -$signed(U_W'(r_q[Q_W-1][j]));
            end else begin
                n_u[j] = $signed(U_W'(r_q[Q_W-1][j]));
            end
        end
    end

    // Valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_trg[0] <= i_res.trig;
            r_flg[0] <= '{sx: i_res.axis.x[IN_W-1], sy: i_res.axis.y[IN_W-1],
                          sz: i_res.axis.z[IN_W-1],
                          zero: (i_res.axis.x == '0) && (i_res.axis.y == '0)
                                && (i_res.axis.z == '0)};
            for (int s = 1; s < LAT - 1; s++) r_flg[s] <= r_flg[s-1];
            // trig rides alongside the unit axis to the output
            for (int s = 1; s < LAT; s++) r_trg[s] <= r_trg[s-1];
            for (int s = 0; s < S_DIV; s++) begin
                for (int j = 0; j < 3; j++) r_mag[s][j] <= n_mag[s][j];
            end
            for (int s = 1; s <= S_LZE; s++) r_mx[s] <= n_mx[s];
            for (int j = 0; j < 3; j++) r_sq[j] <= r_mag[S_LZE][j] * r_mag[S_LZE][j];
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
            for (int k = 0; k < ROOT_W; k++) begin
                r_srem[k] <= n_srem[k];
                r_root[k] <= n_root[k];
                r_sval[k] <= n_sval[k];
            end
            r_len[0] <= r_root[ROOT_W-1];
            for (int k = 1; k < Q_W; k++) r_len[k] <= r_len[k-1];
            for (int k = 0; k < Q_W; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_drem[k][j] <= n_drem[k][j];
                    r_q[k][j]    <= n_q[k][j];
                end
            end
            for (int j = 0; j < 3; j++) r_u[j] <= n_u[j];
        end
    end

    assign o_valid    = r_vld[LAT-1];
    assign o_res.trig = r_trg[LAT-1];
    assign o_res.ux   = r_u[0];
    assign o_res.uy   = r_u[1];
    assign o_res.uz   = r_u[2];

endmodule

### design/aarm_matrix.sv
// Matrix unit: Rodrigues products, sums, rounding and saturation of the nine entries.
module aarm_matrix (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  aarm_pkg::t_norm_res  i_res,
    output logic                 o_valid,
    output aarm_pkg::t_mat       o_mat
);
    localparam int LAT   = aarm_pkg::MAT_LAT;
    localparam int CS_W  = aarm_pkg::CS_W;
    localparam int U_W   = aarm_pkg::U_W;
    localparam int TU_W  = aarm_pkg::TU_W;
    localparam int TP_W  = aarm_pkg::TP_W;
    localparam int ACC_W = aarm_pkg::ACC_W;
    localparam int OUT_W = aarm_pkg::OUT_W;
    localparam int OFB   = aarm_pkg::OUT_FRAC_BITS;
    localparam int FSH   = 60 - OFB;
    localparam logic signed [TP_W-1:0]  RND30  = TP_W'(1) << 29;
    localparam logic signed [ACC_W-1:0] RNDF   = ACC_W'(1) << (FSH - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(1) << OFB;
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;

    logic [LAT-1:0]             r_vld;
    logic signed [TP_W-1:0]     r_p  [0:2];
    logic signed [CS_W-1:0]     r_c  [0:1];
    logic signed [CS_W-1:0]     r_s  [0:1];
    logic signed [U_W-1:0]      r_u  [0:1][0:2];
    logic signed [U_W-1:0]      w_u  [0:2];
    logic signed [TU_W-1:0]     r_tu [0:2];
    logic signed [TP_W-1:0]     w_ps [0:2];
    logic signed [ACC_W-1:0]    r_a  [0:2][0:2];
    logic signed [ACC_W-1:0]    r_b  [0:2];
    logic signed [ACC_W-1:0]    r_cq;
    logic signed [ACC_W-1:0]    r_e  [0:8];
    logic signed [ACC_W-1:0]    n_e  [0:8];
    logic signed [ACC_W-1:0]    w_r  [0:8];
    logic signed [OUT_W-1:0]    r_m  [0:8];
    logic signed [OUT_W-1:0]    n_m  [0:8];

    // Entry sums, rounding and saturation
    always_comb begin
        w_u[0] = i_res.ux;
        w_u[1] = i_res.uy;
        w_u[2] = i_res.uz;
        for (int j = 0; j < 3; j++) w_ps[j] = r_p[j] + RND30;
        n_e[0] = r_a[0][0] + r_cq;
        n_e[1] = r_a[0][1] - r_b[2];
        n_e[2] = r_a[0][2] + r_b[1];
        n_e[3] = r_a[1][0] + r_b[2];
        n_e[4] = r_a[1][1] + r_cq;
        n_e[5] = r_a[1][2] - r_b[0];
        n_e[6] = r_a[2][0] - r_b[1];
        n_e[7] = r_a[2][1] + r_b[0];
        n_e[8] = r_a[2][2] + r_cq;
        for (int k = 0; k < 9; k++) begin
            w_r[k] = (r_e[k] + RNDF) >>> FSH;
            if (w_r[k] > SAT_HI) begin
                n_m[k] = OUT_W'(SAT_HI);
            end else if (w_r[k] < SAT_LO) begin
                n_m[k] = OUT_W'(SAT_LO);
            end else begin
                n_m[k] = OUT_W'(w_r[k]);
            end
        end
    end

    // Valid line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // t * u
            for (int j = 0; j < 3; j++) begin
                r_p[j]    <= i_res.trig.t * w_u[j];
                r_u[0][j] <= w_u[j];
                r_u[1][j] <= r_u[0][j];
            end
            r_c[0] <= i_res.trig.c;
            r_s[0] <= i_res.trig.s;
            r_c[1] <= r_c[0];
            r_s[1] <= r_s[0];
            // rounded t * u
            for (int j = 0; j < 3; j++) r_tu[j] <= TU_W'(w_ps[j] >>> 30);
            // u * t * u and u * s
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) r_a[i][j] <= r_u[1][i] * r_tu[j];
                r_b[i] <= r_u[1][i] * r_s[1];
            end
            r_cq <= ACC_W'(r_c[1]) <<< 30;
            for (int k = 0; k < 9; k++) begin
                r_e[k] <= n_e[k];
                r_m[k] <= n_m[k];
            end
        end
    end

    assign o_valid   = r_vld[LAT-1];
    assign o_mat.m00 = r_m[0];
    assign o_mat.m01 = r_m[1];
    assign o_mat.m02 = r_m[2];
    assign o_mat.m10 = r_m[3];
    assign o_mat.m11 = r_m[4];
    assign o_mat.m12 = r_m[5];
    assign o_mat.m20 = r_m[6];
    assign o_mat.m21 = r_m[7];
    assign o_mat.m22 = r_m[8];

endmodule

### design/axis_angle_rotation_matrix.sv
// Words pass through the angle, axis normalise and matrix units in turn. Throughput: one word
// per cycle unless the output stalls; depth is set by the 18 CORDIC stages and the bit-serial
// square root (32 stages) and divider (31 stages), one bit or rotation per stage.
// A stalled output freezes the whole pipeline; input ready is low only while it is frozen.
// Reset (i_rst_n, synchronous, active low) clears every valid bit; data registers keep
// their contents.
module axis_angle_rotation_matrix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aarm_in_if.sink       i_in,
    aarm_out_if.source    o_out
);
    logic                 w_en;
    logic                 w_ang_vld;
    logic                 w_nrm_vld;
    logic                 w_mat_vld;
    aarm_pkg::t_axis      w_axis;
    aarm_pkg::t_ang_res   w_ang;
    aarm_pkg::t_norm_res  w_nrm;
    aarm_pkg::t_mat       w_mat;

    // Pipeline advances unless a finished word is waiting
    assign w_en       = !w_mat_vld || o_out.ready;
    assign i_in.ready = w_en;
    assign w_axis     = '{x: i_in.axis_x, y: i_in.axis_y, z: i_in.axis_z};

    aarm_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_angle (i_in.angle_deg),
        .i_axis  (w_axis),
        .o_valid (w_ang_vld),
        .o_res   (w_ang)
    );

    aarm_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_ang_vld),
        .i_res   (w_ang),
        .o_valid (w_nrm_vld),
        .o_res   (w_nrm)
    );

    aarm_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_nrm_vld),
        .i_res   (w_nrm),
        .o_valid (w_mat_vld),
        .o_mat   (w_mat)
    );

    // Output word
    assign o_out.valid = w_mat_vld;
    assign o_out.m00   = w_mat.m00;
    assign o_out.m01   = w_mat.m01;
    assign o_out.m02   = w_mat.m02;
    assign o_out.m10   = w_mat.m10;
    assign o_out.m11   = w_mat.m11;
    assign o_out.m12   = w_mat.m12;
    assign o_out.m20   = w_mat.m20;
    assign o_out.m21   = w_mat.m21;
    assign o_out.m22   = w_mat.m22;

endmodule

### design/aarm_checker.sv
// Port-level checks on the rotation matrix block, bound to the top level.
module aarm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic [161:0]  i_mat
);
    // Stalled word stays presented
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    // Stalled word keeps its value
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_mat))
        else $error("output word changed while stalled");

    // Input is refused only while a finished word waits
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output stall");

    // Diagonal entries within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ($signed(i_mat[161:144]) <= 18'sd65536)
            && ($signed(i_mat[161:144]) >= -18'sd65536)
            && ($signed(i_mat[89:72]) <= 18'sd65536)
            && ($signed(i_mat[89:72]) >= -18'sd65536)
            && ($signed(i_mat[17:0]) <= 18'sd65536)
            && ($signed(i_mat[17:0]) >= -18'sd65536))
        else $error("diagonal entry out of range");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_mat       ({o_out.m00, o_out.m01, o_out.m02, o_out.m10, o_out.m11,
                   o_out.m12, o_out.m20, o_out.m21, o_out.m22})
);
